// ===== rtl/sorted_list_kway_merge_top_macros.svh =====
// Assertion macros for the k-way merge block
`ifndef SORTED_LIST_KWAY_MERGE_TOP_MACROS_SVH
`define SORTED_LIST_KWAY_MERGE_TOP_MACROS_SVH
// assert that a implies b on the next edge
`define SKM_ASSERT_NEXT(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);
// assert that a implies b on the same edge
`define SKM_ASSERT_NOW(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);
`endif

// ===== rtl/skm_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// skm_pkg
// Shared types and codes of the k-way merge block.
// ---------------------------------------------------------------------------
package skm_pkg;
  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [9:0] LIMIT_RESET = 10'd100;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_LAST, ST_POPRD, ST_OUT
  } state_t;
endpackage

// ===== rtl/sorted_list_kway_merge_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sorted_list_kway_merge_top
// Merges up to LISTS sorted lists into one nearest-first stream.
// ---------------------------------------------------------------------------
// Usage: s_axis words carry one command in tuser: load, pop or clear. A load
// appends (distance, label) to a list and sets its id base; a pop returns one
// m_axis word with the least head over all lists; clear empties all lists.
// cfg_valid/cfg_ready write out_limit only while the block is idle: the user
// must keep to that, as the block itself does not enforce it. A clear reruns
// the pointer clear pass. A pop walks every list once through the per-list
// fill/position memory and the entry memory, one list a cycle, then updates
// the chosen list's position and registers its word.
// One command is worked at a time. The result sits in an output register;
// when the receiver stalls, m_axis_tvalid holds and no new command is taken
// until the word leaves. Reset clears fill counts, read positions (a clear
// pass over that memory), pop count and overflow flag. Never-written entry
// stores are undefined and never read.
// ---------------------------------------------------------------------------
`include "sorted_list_kway_merge_top_macros.svh"
module sorted_list_kway_merge_top import skm_pkg::*; #(
  parameter int LISTS = 64,
  parameter int DEPTH = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: list_index[5:0], entry_distance[37:6], entry_label[69:38],
  // list_base[101:70], zero fill [103:102]
  input  logic [103:0] s_axis_tdata,
  // tuser: operation[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: result_id[32:0], distance[64:33], zero fill
  output logic [71:0] m_axis_tdata,
  // tuser: empty_res[0], overflowed[1]
  output logic [1:0]  m_axis_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [9:0]  cfg_data
);
  localparam int LW = (LISTS > 1) ? $clog2(LISTS) : 1;
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = LW + PW;

  // memories
  logic [31:0]   dist_mem [2**AW];
  logic [31:0]   lab_mem  [2**AW];
  logic [31:0]   base_mem [2**LW];
  logic [2*CW-1:0] ptr_mem [2**LW]; // {position, fill}

  state_t state, state_next;
  logic [9:0] out_limit, pop_count;
  logic ovf;
  logic [LW:0] clr_cnt;
  logic clearing;
  logic [1:0]  op;
  logic [5:0]  li;
  logic [31:0] in_d, in_l, in_b;
  logic [LW:0] scan;          // list being read from pointer memory
  logic        ptr_vld;       // pointer read data valid this cycle
  logic [LW-1:0] ptr_idx;
  logic [2*CW-1:0] ptr_rd;
  logic        ent_vld;
  logic [LW-1:0] ent_idx;
  logic [CW-1:0] ent_pos;
  logic [31:0] dist_rd, lab_rd, base_rd;
  logic        found;
  logic [31:0] bd, bl;
  logic [CW-1:0] bp;
  logic [LW-1:0] bi;
  logic        ld_wait;
  logic        mv;
  logic [71:0] mdata;
  logic [1:0]  muser;

  assign clearing = !clr_cnt[LW];
  assign s_axis_tready = (state == ST_IDLE) && !clearing && !mv && !ld_wait;
  assign cfg_ready = 1'b1;
  assign m_axis_tvalid = mv;
  assign m_axis_tdata = mdata;
  assign m_axis_tuser = muser;

  wire acc = s_axis_tvalid && s_axis_tready;
  wire [CW-1:0] p_pos  = ptr_rd[2*CW-1:CW];
  wire [CW-1:0] p_fill = ptr_rd[CW-1:0];
  wire list_ok = (32'(li) < 32'(LISTS));
  wire [LW-1:0] li_i = LW'(li);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (acc && s_axis_tuser == OP_POP) state_next = ST_SCAN;
      ST_SCAN:  if (scan == (LW+1)'(LISTS - 1)) state_next = ST_LAST;
      ST_LAST:  if (!ptr_vld && !ent_vld) state_next = ST_POPRD;
      ST_POPRD: state_next = ST_OUT;
      ST_OUT:   state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // pointer memory: read one list a cycle, write on load/pop/clear
  logic ptr_we;
  logic [LW-1:0] ptr_wa;
  logic [2*CW-1:0] ptr_wd;
  always_comb begin
    ptr_we = 1'b0; ptr_wa = li_i; ptr_wd = ptr_rd;
    if (clearing) begin
      ptr_we = 1'b1; ptr_wa = clr_cnt[LW-1:0]; ptr_wd = '0;
    end else if (ld_wait && op == OP_LOAD && list_ok && p_fill != CW'(DEPTH)) begin
      ptr_we = 1'b1; ptr_wa = li_i; ptr_wd = {p_pos, p_fill + CW'(1)};
    end else if (state == ST_POPRD && found) begin
      ptr_we = 1'b1; ptr_wa = bi; ptr_wd = {bp + CW'(1), ptr_rd[CW-1:0]};
    end
  end

  logic [LW-1:0] ptr_ra;
  always_comb begin
    ptr_ra = li_i;
    if (state == ST_SCAN) ptr_ra = scan[LW-1:0];
    else if (state == ST_LAST) ptr_ra = bi;
    else if (acc) ptr_ra = LW'(s_axis_tdata[5:0]);
  end

  always_ff @(posedge clk) begin
    if (ptr_we) ptr_mem[ptr_wa] <= ptr_wd;
    ptr_rd <= ptr_mem[ptr_ra];
  end

  // entry memories
  wire ent_we = ld_wait && op == OP_LOAD && list_ok && p_fill != CW'(DEPTH);
  wire [AW-1:0] ent_wa = {li_i, p_fill[PW-1:0]};
  wire [AW-1:0] ent_ra = {ptr_idx, p_pos[PW-1:0]};
  always_ff @(posedge clk) begin
    if (ent_we) begin
      dist_mem[ent_wa] <= in_d;
      lab_mem[ent_wa]  <= in_l;
    end
    dist_rd <= dist_mem[ent_ra];
    lab_rd  <= lab_mem[ent_ra];
  end
  always_ff @(posedge clk) begin
    if (ld_wait && op == OP_LOAD && list_ok) base_mem[li_i] <= in_b;
    base_rd <= base_mem[bi];
  end

  // head compare: lower distance wins, then lower label, then lower position; a full tie keeps the list scanned first
  wire better = !found || dist_rd < bd || (dist_rd == bd &&
                (lab_rd < bl || (lab_rd == bl && ent_pos < bp)));

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0; out_limit <= LIMIT_RESET; pop_count <= '0; ovf <= 1'b0;
      ld_wait <= 1'b0; mv <= 1'b0; scan <= '0; ptr_vld <= 1'b0; ent_vld <= 1'b0;
      found <= 1'b0;
    end else begin
      if (clearing) clr_cnt <= clr_cnt + (LW+1)'(1);
      if (cfg_valid && cfg_ready) out_limit <= cfg_data;
      if (mv && m_axis_tready) mv <= 1'b0;
      ld_wait <= acc && s_axis_tuser == OP_LOAD;
      if (acc) begin
        op <= s_axis_tuser; li <= s_axis_tdata[5:0];
        in_d <= s_axis_tdata[37:6]; in_l <= s_axis_tdata[69:38];
        in_b <= s_axis_tdata[101:70];
        if (s_axis_tuser == OP_CLEAR) begin
          clr_cnt <= '0; pop_count <= '0;
        end
        scan <= '0; found <= 1'b0;
      end
      if (ld_wait && op == OP_LOAD && list_ok && p_fill == CW'(DEPTH)) ovf <= 1'b1;
      ptr_vld <= (state == ST_SCAN);
      ptr_idx <= scan[LW-1:0];
      if (state == ST_SCAN) scan <= scan + (LW+1)'(1);
      ent_vld <= ptr_vld && (p_pos < p_fill) && (pop_count < out_limit);
      ent_idx <= ptr_idx; ent_pos <= p_pos;
      if (ent_vld && better) begin
        found <= 1'b1; bd <= dist_rd; bl <= lab_rd; bp <= ent_pos; bi <= ent_idx;
      end
      if (state == ST_POPRD && found) pop_count <= pop_count + 10'd1;
      if (state == ST_OUT) begin
        mv <= 1'b1;
        mdata <= found ? {7'd0, bd, 33'(base_rd) + 33'(bl)} : '0;
        muser <= {ovf, !found};
      end
    end
  end

  `SKM_ASSERT_NOW(a_no_accept_busy, clk, rst, s_axis_tready, state == ST_IDLE && !mv,
    "input accepted while busy")
  `SKM_ASSERT_NEXT(a_out_hold, clk, rst, mv && !m_axis_tready, mv && $stable(mdata),
    "result dropped under stall")
  `SKM_ASSERT_NEXT(a_ovf_sticky, clk, rst, ovf, ovf, "overflow flag cleared")
endmodule
